FILE: rtl/bracket_balance_checker_defines.svh
// Assertion macros used by the bracket balance checker's checker file.
`ifndef BRACKET_BALANCE_CHECKER_DEFINES_SVH
`define BRACKET_BALANCE_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBC_ASSERT_NOW(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("bracket balance checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define BBC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("bracket balance checker: next-cycle property failed");

`endif

FILE: rtl/bbc_pkg.sv
// Package with types, codes and constants of the bracket balance checker.
`timescale 1ns / 1ps
package bbc_pkg;

	// Default sizes handed to the top level.
	localparam int STACK_DEPTH_DEF = 32;
	localparam int LINE_BITS_DEF   = 20;

	// Width of the line field in a result.
	localparam int LINE_W = 20;

	// Depth of the command queue between front and back.
	localparam int CMD_FIFO_DEPTH = 4;

	// Input kinds.
	localparam logic KIND_TEXT = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// Character codes of interest.
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_LSQUARE = 8'h5B;
	localparam logic [7:0] CH_RSQUARE = 8'h5D;
	localparam logic [7:0] CH_LCURLY  = 8'h7B;
	localparam logic [7:0] CH_RCURLY  = 8'h7D;

	// Bracket types.
	localparam logic [1:0] BR_ROUND  = 2'd0;
	localparam logic [1:0] BR_SQUARE = 2'd1;
	localparam logic [1:0] BR_CURLY  = 2'd2;

	// Report kinds.
	localparam logic [1:0] RPT_MISMATCH = 2'd0;
	localparam logic [1:0] RPT_MISSING  = 2'd1;
	localparam logic [1:0] RPT_OVERFLOW = 2'd2;
	localparam logic [1:0] RPT_END      = 2'd3;

	// Classified operations passed from front to back.
	typedef enum logic [1:0] {
		OP_NEWLINE = 2'd0,
		OP_OPEN    = 2'd1,
		OP_CLOSE   = 2'd2,
		OP_END     = 2'd3
	} bbc_op_t;

	// One queued command.
	typedef struct packed {
		bbc_op_t    op;
		logic [1:0] btype;
	} bbc_cmd_t;

	// Input item.
	typedef struct packed {
		logic       kind;
		logic [7:0] char_code;
	} in_item_t;

	// Result item.
	typedef struct packed {
		logic [1:0]        report_kind;
		logic [1:0]        bracket_type;
		logic [LINE_W-1:0] line_number;
		logic              last_of_run;
	} out_item_t;

endpackage

FILE: rtl/bbc_front.sv
// Front part: accepts text items and classifies them into queue commands.
`timescale 1ns / 1ps
module bbc_front
	import bbc_pkg::*;
(
	input  logic     item_valid,
	output logic     item_ready,
	input  in_item_t item,
	output logic     push_valid,
	input  logic     push_ready,
	output bbc_cmd_t push_cmd
);

	logic keep;

	// Classify the byte; bytes that do nothing are accepted and dropped.
	always_comb begin
		keep           = 1'b1;
		push_cmd.op    = OP_NEWLINE;
		push_cmd.btype = BR_ROUND;
		priority if (item.kind == KIND_END) begin
			push_cmd.op = OP_END;
		end else begin
			unique case (item.char_code)
				CH_NEWLINE: push_cmd.op = OP_NEWLINE;
				CH_LPAREN: begin
					push_cmd.op    = OP_OPEN;
					push_cmd.btype = BR_ROUND;
				end
				CH_LSQUARE: begin
					push_cmd.op    = OP_OPEN;
					push_cmd.btype = BR_SQUARE;
				end
				CH_LCURLY: begin
					push_cmd.op    = OP_OPEN;
					push_cmd.btype = BR_CURLY;
				end
				CH_RPAREN: begin
					push_cmd.op    = OP_CLOSE;
					push_cmd.btype = BR_ROUND;
				end
				CH_RSQUARE: begin
					push_cmd.op    = OP_CLOSE;
					push_cmd.btype = BR_SQUARE;
				end
				CH_RCURLY: begin
					push_cmd.op    = OP_CLOSE;
					push_cmd.btype = BR_CURLY;
				end
				default: keep = 1'b0;
			endcase
		end
	end

	// A transfer is taken whenever the queue has room.
	assign item_ready = push_ready;
	assign push_valid = item_valid && keep;

endmodule

FILE: rtl/bbc_fifo.sv
// Short command queue that decouples the front from the back.
`timescale 1ns / 1ps
module bbc_fifo
	import bbc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  bbc_cmd_t push_cmd,
	output logic     pop_valid,
	input  logic     pop,
	output bbc_cmd_t pop_cmd
);

	localparam int PW = $clog2(CMD_FIFO_DEPTH);

	bbc_cmd_t      entry_q [CMD_FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   fill_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (fill_q != (PW + 1)'(CMD_FIFO_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + (PW + 1)'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - (PW + 1)'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

FILE: rtl/bbc_back.sv
// Back part: line counter, bracket stack and result register.
`timescale 1ns / 1ps
module bbc_back
	import bbc_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int LINE_BITS   = LINE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  bbc_cmd_t  cmd,
	output logic      cmd_pop,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int EW = LINE_BITS + 2;
	localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

	logic [EW-1:0]        stack_mem [STACK_DEPTH];
	logic [EW-1:0]        top_q;
	logic [EW-1:0]        rd_q;
	logic                 top_rd_q;
	logic [CW-1:0]        count_q;
	logic [LINE_BITS-1:0] line_q;
	logic                 out_valid_q;
	out_item_t            out_q;

	logic [EW-1:0]        top_e;
	logic [1:0]           top_type;
	logic [LINE_BITS-1:0] top_line;
	logic [AW-1:0]        rd_addr;
	logic [EW-1:0]        push_e;
	logic                 need_out;
	logic                 take_cmd;
	logic                 do_push_c;
	logic                 do_pop_c;
	logic                 do_newline_c;
	logic                 do_clear_c;
	out_item_t            res_c;
	logic                 slot_free;
	logic                 fire;

	// Cut a line count to the result field width.
	function automatic logic [LINE_W-1:0] to_out_line(input logic [LINE_BITS-1:0] l);
		logic [LINE_BITS+LINE_W-1:0] ext;
		ext = {{LINE_W{1'b0}}, l};
		return ext[LINE_W-1:0];
	endfunction

	// The top entry sits in top_q after a push and in rd_q after a pop.
	assign top_e    = top_rd_q ? rd_q : top_q;
	assign top_type = top_e[EW-1 -: 2];
	assign top_line = top_e[LINE_BITS-1:0];
	assign rd_addr  = AW'(count_q - CW'(2));
	assign push_e   = {cmd.btype, line_q};

	// Decide what the head command does and whether it makes a result.
	always_comb begin
		need_out     = 1'b0;
		take_cmd     = 1'b1;
		do_push_c    = 1'b0;
		do_pop_c     = 1'b0;
		do_newline_c = 1'b0;
		do_clear_c   = 1'b0;
		res_c.report_kind  = RPT_MISMATCH;
		res_c.bracket_type = cmd.btype;
		res_c.line_number  = to_out_line(line_q);
		res_c.last_of_run  = 1'b0;
		unique case (cmd.op)
			OP_NEWLINE: do_newline_c = 1'b1;
			OP_OPEN: begin
				if (count_q == FULL) begin
					need_out          = 1'b1;
					res_c.report_kind = RPT_OVERFLOW;
				end else begin
					do_push_c = 1'b1;
				end
			end
			OP_CLOSE: begin
				if (count_q == '0 || top_type != cmd.btype) begin
					need_out          = 1'b1;
					res_c.report_kind = RPT_MISMATCH;
				end else begin
					do_pop_c = 1'b1;
				end
			end
			OP_END: begin
				need_out = 1'b1;
				if (count_q != '0) begin
					// Drain one unclosed opener per cycle while the result slot is free, holding the command.
					take_cmd           = 1'b0;
					do_pop_c           = 1'b1;
					res_c.report_kind  = RPT_MISSING;
					res_c.bracket_type = top_type;
					res_c.line_number  = to_out_line(top_line);
				end else begin
					do_clear_c         = 1'b1;
					res_c.report_kind  = RPT_END;
					res_c.bracket_type = BR_ROUND;
					res_c.last_of_run  = 1'b1;
				end
			end
			default: take_cmd = 1'b1;
		endcase
	end

	assign slot_free    = !out_valid_q || result_ready;
	assign fire         = cmd_valid && (!need_out || slot_free);
	assign cmd_pop      = fire && take_cmd;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// Control state: stack depth, line counter, top location, result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			line_q      <= LINE_BITS'(1);
			top_rd_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire && need_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			if (fire) begin
				if (do_push_c) begin
					count_q  <= count_q + CW'(1);
					top_rd_q <= 1'b0;
				end
				if (do_pop_c) begin
					count_q  <= count_q - CW'(1);
					top_rd_q <= 1'b1;
				end
				if (do_newline_c && !(&line_q)) begin
					line_q <= line_q + LINE_BITS'(1);
				end
				if (do_clear_c) begin
					line_q <= LINE_BITS'(1);
				end
			end
		end
	end

	// Stack memory, top cache and result payload.
	always_ff @(posedge clk) begin
		if (fire && do_push_c) begin
			stack_mem[count_q[AW-1:0]] <= push_e;
			top_q                      <= push_e;
		end
		if (fire && do_pop_c) begin
			rd_q <= stack_mem[rd_addr];
		end
		if (fire && need_out) begin
			out_q <= res_c;
		end
	end

endmodule

FILE: rtl/bracket_balance_checker.sv
// Top level of the bracket balance checker.
//
// Input channel item_valid/item_ready/item carries one text byte or an end
// of text per transfer. Output channel result_valid/result_ready/result
// carries reports: mismatched close, missing close, stack overflow and the
// end marker, which has last_of_run set.
// A front stage classifies each byte into a four-entry command queue; the
// back stage owns the line counter, the bracket stack memory and a single
// result register. Text bytes go through at one per cycle while the queue
// has room. The command behind a report is registered in the queue, and the
// report then in the result register. An end of text makes one missing-close
// report per stacked bracket, popping each through the single read port of
// the stack memory, then the end marker, which returns the line count to one.
// Reset clears the queue, the stack depth, the result valid and sets the
// line counter to one; stack contents are not cleared.
// While the receiver holds result_ready low, bytes that make no report keep
// flowing; the queue fills and item_ready drops only when a report is
// waiting behind the held one.
`timescale 1ns / 1ps
module bracket_balance_checker
	import bbc_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int LINE_BITS   = LINE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	logic     push_valid;
	logic     push_ready;
	bbc_cmd_t push_cmd;
	logic     cmd_valid;
	logic     cmd_pop;
	bbc_cmd_t cmd;

	// Byte classification.
	bbc_front u_front (
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	// Command queue.
	bbc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (cmd_valid),
		.pop        (cmd_pop),
		.pop_cmd    (cmd)
	);

	// Stack, line counter and results.
	bbc_back #(
		.STACK_DEPTH (STACK_DEPTH),
		.LINE_BITS   (LINE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

FILE: rtl/bbc_checker.sv
// Port-level checker of the bracket balance checker, bound to the top level.
`timescale 1ns / 1ps
`include "bracket_balance_checker_defines.svh"
module bbc_checker
	import bbc_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      result_valid,
	input logic      result_ready,
	input out_item_t result
);

	// A held result stays put until its transfer.
	`BBC_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result))

	// Only the end marker is flagged last.
	`BBC_ASSERT_NOW(a_last_is_end, clk, arst_n, result_valid, result.last_of_run == (result.report_kind == RPT_END))

	// The end marker carries the round type code.
	`BBC_ASSERT_NOW(a_end_type, clk, arst_n, result_valid && result.report_kind == RPT_END, result.bracket_type == BR_ROUND)

	// Bracket type is always one of the three kinds.
	`BBC_ASSERT_NOW(a_type_range, clk, arst_n, result_valid, result.bracket_type != 2'd3)

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
